### rtl/bc_pkg.sv
package bc_pkg;

    localparam int N_W    = 6;
    localparam int K_W    = 6;
    localparam int COEF_W = 30;
    localparam int N_MAX  = 32;
    localparam int PROD_W = COEF_W + N_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_last;
    } t_sts;

endpackage

### rtl/binomial_coefficient.sv
// A request runs k steps of the recurrence when 0 < k <= n <= N_MAX,
// and none otherwise.
// Each of the k steps runs a multiply, a division in the bit-serial
// divider and a check.
// One request is in work at a time, so a new request is taken only in idle.
// Reset (synchronous, active low) clears the controller and the result valid.
module binomial_coefficient
    import bc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [N_W-1:0]    i_n,
    input  logic [K_W-1:0]    i_k,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COEF_W-1:0] o_coefficient
);

    t_cmd w_cmd;
    t_sts w_sts;

    bc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    bc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n           (i_n),
        .i_k           (i_k),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_coefficient (o_coefficient)
    );

endmodule

### rtl/bc_dpath.sv
module bc_dpath
    import bc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [N_W-1:0]    i_n,
    input  logic [K_W-1:0]    i_k,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [COEF_W-1:0] o_coefficient
);

    logic [N_W-1:0]    r_n;
    logic [K_W-1:0]    r_k;
    logic [K_W-1:0]    r_i;
    logic              r_special;
    logic [COEF_W-1:0] r_r;
    logic [PROD_W-1:0] r_q;
    logic [N_W-1:0]    r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [COEF_W-1:0] r_coef;

    logic [N_W-1:0]    w_factor;
    logic [PROD_W-1:0] w_prod;
    logic [N_W:0]      w_trial;
    logic [N_W:0]      w_divisor;
    logic              w_ge;
    logic [N_W-1:0]    w_diff;
    logic [PROD_W-1:0] w_q_next;

    assign w_factor  = r_n - N_W'(r_i) + N_W'(1);
    assign w_prod    = r_r * w_factor;
    assign w_trial   = {r_rem, r_q[PROD_W-1]};
    assign w_divisor = {1'b0, r_i};
    assign w_ge      = (w_trial >= w_divisor);
    assign w_diff    = w_ge ? N_W'(w_trial - w_divisor) : w_trial[N_W-1:0];
    assign w_q_next  = {r_q[PROD_W-2:0], w_ge};

    assign o_sts.last     = r_special || (r_i > r_k);
    assign o_sts.div_last = (r_cnt == CNT_W'(1));
    assign o_coefficient  = r_coef;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n       <= i_n;
            r_k       <= i_k;
            r_i       <= K_W'(1);
            r_special <= (i_n > N_W'(N_MAX)) || (i_k > i_n);
            r_r       <= ((i_n > N_W'(N_MAX)) || (i_k > i_n)) ? '0 : COEF_W'(1);
        end
        if (i_cmd.mul) begin
            r_q   <= w_prod;
            r_rem <= '0;
            r_cnt <= CNT_W'(PROD_W);
        end
        if (i_cmd.div_step) begin
            r_q   <= w_q_next;
            r_rem <= w_diff;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_r <= w_q_next[COEF_W-1:0];
                r_i <= r_i + K_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_coef <= r_r;
        end
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < N_W'(r_i)))
        else $error("remainder not below divisor");

    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && (r_cnt == CNT_W'(1))) |=> (r_i == K_W'($past(r_i) + K_W'(1))))
        else $error("index did not advance after a division");
`endif

endmodule

### rtl/bc_ctrl.sv
module bc_ctrl
    import bc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cmd.load     = i_valid && (r_state == S_IDLE);
    assign o_cmd.mul      = (r_state == S_MUL);
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.emit     = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= i_sts.last ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CHECK))
        else $error("accepted request did not start");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && i_sts.div_last) |=> (r_state == S_CHECK))
        else $error("division did not return to check");
`endif

endmodule

### test/tb_binomial_coefficient.sv
`timescale 1ns / 100ps

module tb_binomial_coefficient
    import bc_pkg::*;
();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int WORST_LATENCY = 1250;
    localparam int HOLD_CYCLES   = 3000;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [N_W-1:0]    n;
        logic [K_W-1:0]    k;
        logic [COEF_W-1:0] coef;
    } t_binom_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [N_W-1:0]    i_n;
    logic [K_W-1:0]    i_k;
    logic              o_valid;
    logic              i_stall;
    logic [COEF_W-1:0] o_coefficient;

    t_binom_req pending_results[$];

    int cycle_count;
    int error_count;
    int mismatch_count;
    int sent_count;
    int checked_count;
    int zero_count;
    int long_count;
    int input_held_cycles;
    int burst_left;
    bit gaps_on;
    bit rx_free_run;
    int hold_requests;

    binomial_coefficient i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_n           (i_n),
        .i_k           (i_k),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [COEF_W-1:0] binomial_of(logic [N_W-1:0] n, logic [K_W-1:0] k);
        longint unsigned acc;
        acc = 1;
        if (n > N_MAX || k > n) begin
            return '0;
        end
        for (int unsigned i = 1; i <= k; i++) begin
            acc = acc * (n - i + 1) / i;
        end
        return acc[COEF_W-1:0];
    endfunction

    // The receiver stalls in phases of random length, each with its own pattern,
    // unless a long hold-off has been requested by a test or the receiver runs free.
    initial begin
        int mode;
        int phase_left;
        int run_left;
        int pattern_cnt;
        int hold_left;
        int hold_seen;
        bit run_stall;
        mode = 0;
        phase_left = 0;
        run_left = 0;
        pattern_cnt = 0;
        hold_left = 0;
        hold_seen = 0;
        run_stall = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            pattern_cnt++;
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_free_run) begin
                i_stall <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 120);
                end else begin
                    phase_left--;
                end
                case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_stall <= (pattern_cnt % 4) != 0;
                    end
                    default: begin
                        if (run_left == 0) begin
                            run_stall = ~run_stall;
                            run_left = $urandom_range(1, 16);
                        end else begin
                            run_left--;
                        end
                        i_stall <= run_stall;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_binom_req want;
        if (i_rst_n === 1'b1) begin
            if (i_valid && o_stall === 1'b1) begin
                input_held_cycles++;
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("Unexpected result %0d at cycle %0d.", o_coefficient, cycle_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (o_coefficient !== want.coef) begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("Mismatch for C(%0d,%0d): expected %0d, got %0d.",
                                     want.n, want.k, want.coef, o_coefficient);
                        end
                    end
                end
            end
        end
    end

    task automatic send_request(input int n, input int k);
        t_binom_req req;
        i_valid <= 1'b1;
        i_n <= N_W'(n);
        i_k <= K_W'(k);
        do @(posedge i_clk); while (o_stall !== 1'b0);
        req.n = N_W'(n);
        req.k = K_W'(k);
        req.coef = binomial_of(req.n, req.k);
        pending_results.push_back(req);
        sent_count++;
        if (req.coef == 0) begin
            zero_count++;
        end
        if (n <= N_MAX && k <= n && k >= 10) begin
            long_count++;
        end
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            burst_left = $urandom_range(0, 12);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    endtask

    task automatic test_edge_cases();
        send_request(0, 0);
        send_request(0, 1);
        send_request(1, 0);
        send_request(1, 1);
        send_request(2, 1);
        send_request(32, 0);
        send_request(32, 1);
        send_request(32, 16);
        send_request(32, 15);
        send_request(32, 31);
        send_request(32, 32);
        send_request(31, 15);
        send_request(20, 10);
        send_request(5, 6);
        send_request(31, 32);
        send_request(32, 33);
        send_request(0, 63);
        send_request(33, 0);
        send_request(33, 33);
        send_request(40, 20);
        send_request(63, 1);
        send_request(63, 63);
    endtask

    task automatic test_back_to_back();
        int n;
        gaps_on = 1'b0;
        rx_free_run = 1'b1;
        for (int i = 0; i < 30; i++) begin
            n = $urandom_range(0, N_MAX);
            send_request(n, $urandom_range(0, 4));
        end
        gaps_on = 1'b1;
        rx_free_run = 1'b0;
    endtask

    task automatic test_output_hold_off();
        gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 8; i++) begin
            send_request($urandom_range(0, N_MAX), $urandom_range(0, 3));
        end
        gaps_on = 1'b1;
    endtask

    // Most requests use small choice counts, since each step of k costs a
    // full divide; only a few go deep into the recurrence.
    task automatic test_random_requests(input int count);
        int n;
        int k;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                n = $urandom_range(0, N_MAX);
                k = $urandom_range(0, (n < 5) ? n : 5);
            end else if (sel < 70) begin
                n = $urandom_range(0, N_MAX);
                k = $urandom_range(0, 1) ? n : 0;
            end else if (sel < 80) begin
                n = $urandom_range(0, N_MAX - 1);
                k = $urandom_range(n + 1, 63);
            end else if (sel < 90) begin
                n = $urandom_range(N_MAX + 1, 63);
                k = $urandom_range(0, 63);
            end else if (sel < 95) begin
                n = $urandom_range(20, N_MAX);
                k = $urandom_range(10, n);
            end else begin
                n = $urandom_range(0, 63);
                k = $urandom_range(0, 63);
            end
            send_request(n, k);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_n = '0;
        i_k = '0;
        cycle_count = 0;
        error_count = 0;
        mismatch_count = 0;
        sent_count = 0;
        checked_count = 0;
        zero_count = 0;
        long_count = 0;
        input_held_cycles = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        rx_free_run = 1'b0;
        hold_requests = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_back_to_back();
        test_output_hold_off();
        test_random_requests(RANDOM_ITEMS);

        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (WORST_LATENCY) @(posedge i_clk);

        $display("Checked %0d results for %0d requests: %0d zero, %0d with k of 10 or more.",
                 checked_count, sent_count, zero_count, long_count);
        $display("The input was held back for %0d cycles; %0d mismatches in total.",
                 input_held_cycles, mismatch_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bc_pkg.sv
rtl/bc_dpath.sv
rtl/bc_ctrl.sv
rtl/binomial_coefficient.sv
test/tb_binomial_coefficient.sv
